// File: rtl/pnsc_pkg.sv
`default_nettype none

package pnsc_pkg;

    // Kind of name selected by the configuration register
    typedef enum logic [1:0] {
        KIND_WORD   = 2'd0,
        KIND_PATH   = 2'd1,
        KIND_DOMAIN = 2'd2,
        KIND_UNUSED = 2'd3
    } name_kind_t;

    // Escape decoder phase
    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_OPEN  = 2'd1,
        ESC_OCT1  = 2'd2,
        ESC_OCT2  = 2'd3
    } esc_phase_t;

    // Per-name checker state
    typedef struct packed {
        esc_phase_t  escape_phase;
        logic [5:0]  octal_value;
        logic        in_group;
        logic        close_pending;
        logic        prior_was_slash;
        logic        token_started;
        logic        first_token;
        logic [1:0]  token_length;
        logic [7:0]  held_byte;
        logic        failed;
    } pnsc_state_t;

    localparam pnsc_state_t STATE_RESET = '{
        escape_phase:    ESC_NONE,
        octal_value:     6'd0,
        in_group:        1'b0,
        close_pending:   1'b0,
        prior_was_slash: 1'b0,
        token_started:   1'b0,
        first_token:     1'b1,
        token_length:    2'd0,
        held_byte:       8'd0,
        failed:          1'b0
    };

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

endpackage

`default_nettype wire

// File: rtl/pnsc_step.sv
`default_nettype none

// Next-state and verdict logic for one byte of a name
module pnsc_step
    import pnsc_pkg::*;
(
    input  wire name_kind_t  kind,
    input  wire pnsc_state_t cur,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output pnsc_state_t      nxt,
    output logic             name_valid
);

    // Reset only the word-level fields
    function automatic pnsc_state_t word_clear(input pnsc_state_t s);
        pnsc_state_t r;
        r = s;
        r.escape_phase    = ESC_NONE;
        r.octal_value     = 6'd0;
        r.in_group        = 1'b0;
        r.close_pending   = 1'b0;
        r.prior_was_slash = 1'b0;
        return r;
    endfunction

    // Word must not end inside an escape, a group or before a required '/'
    function automatic pnsc_state_t word_end(input pnsc_state_t s);
        pnsc_state_t r;
        r = s;
        if (s.escape_phase != ESC_NONE || s.in_group || s.close_pending)
            r.failed = 1'b1;
        return r;
    endfunction

    // One byte through the escape decoder
    function automatic pnsc_state_t word_feed(input pnsc_state_t s, input logic [7:0] c);
        pnsc_state_t r;
        logic        skip;
        logic [8:0]  oct_val;
        r       = s;
        skip    = 1'b0;
        oct_val = {s.octal_value, c[2:0]};
        unique case (s.escape_phase)
            ESC_NONE:
            begin
                if (s.close_pending)
                begin
                    r.close_pending = 1'b0;
                    if (c != CH_SLASH)
                    begin
                        r.failed = 1'b1;
                        skip     = 1'b1;
                    end
                end
                if (!skip)
                begin
                    if (c == CH_BSLASH)
                        r.escape_phase = ESC_OPEN;
                    else
                    begin
                        if ((s.in_group && c == CH_SLASH) || c <= CH_SPACE || c >= CH_DEL)
                            r.failed = 1'b1;
                        r.prior_was_slash = (c == CH_SLASH);
                    end
                end
            end
            ESC_OPEN:
            begin
                r.prior_was_slash = 1'b0;
                r.escape_phase    = ESC_NONE;
                case (c) inside
                    "\\", "$", "+", "?", "*", "@", "x", "X", "a", "A", "-":
                    begin
                    end
                    "{":
                    begin
                        if (!s.prior_was_slash)
                            r.failed = 1'b1;
                        r.in_group = 1'b1;
                    end
                    "}":
                    begin
                        if (!s.in_group)
                            r.failed = 1'b1;
                        r.in_group      = 1'b0;
                        r.close_pending = 1'b1;
                    end
                    "0", "1", "2", "3":
                    begin
                        r.octal_value  = {4'd0, c[1:0]};
                        r.escape_phase = ESC_OCT1;
                    end
                    default:
                        r.failed = 1'b1;
                endcase
            end
            default:
            begin
                // octal digits: '0' through '7'
                if (c[7:3] != 5'b00110)
                begin
                    r.failed       = 1'b1;
                    r.escape_phase = ESC_NONE;
                end
                else if (s.escape_phase == ESC_OCT1)
                begin
                    r.octal_value  = {s.octal_value[2:0], c[2:0]};
                    r.escape_phase = ESC_OCT2;
                end
                else
                begin
                    // printable values may not be written as octal
                    if (oct_val > 9'd32 && oct_val < 9'd127)
                        r.failed = 1'b1;
                    r.escape_phase = ESC_NONE;
                end
            end
        endcase
        return r;
    endfunction

    pnsc_state_t s;

    always_comb
    begin
        s = cur;
        // byte update by kind
        unique case (kind)
            KIND_WORD:
                s = word_feed(s, data_byte);
            KIND_PATH:
            begin
                if (!s.token_started)
                begin
                    s.token_started = 1'b1;
                    if (data_byte != CH_SLASH)
                        s.failed = 1'b1;
                end
                s = word_feed(s, data_byte);
            end
            KIND_DOMAIN:
            begin
                if (s.first_token)
                begin
                    if (data_byte == CH_SPACE)
                    begin
                        if (s.token_length != 2'd3 || s.held_byte != CH_GT)
                            s.failed = 1'b1;
                        s = word_end(s);
                        s.first_token   = 1'b0;
                        s.token_started = 1'b0;
                        s = word_clear(s);
                    end
                    else
                    begin
                        // inner bytes are held one step: the last may be '>'
                        if (s.token_length == 2'd0)
                        begin
                            if (data_byte != CH_LT)
                                s.failed = 1'b1;
                        end
                        else if (s.token_length == 2'd1)
                            s.held_byte = data_byte;
                        else
                        begin
                            s = word_feed(s, cur.held_byte);
                            s.held_byte = data_byte;
                        end
                        if (s.token_length != 2'd3)
                            s.token_length = s.token_length + 2'd1;
                    end
                end
                else if (data_byte == CH_SPACE)
                begin
                    if (!s.token_started)
                        s.failed = 1'b1;
                    s = word_end(s);
                    s.token_started = 1'b0;
                    s = word_clear(s);
                end
                else
                begin
                    if (!s.token_started)
                    begin
                        s.token_started = 1'b1;
                        if (data_byte != CH_SLASH)
                            s.failed = 1'b1;
                    end
                    s = word_feed(s, data_byte);
                end
            end
            default:
                s.failed = 1'b1;
        endcase

        // end-of-name checks
        if (last_byte)
        begin
            unique case (kind)
                KIND_WORD, KIND_PATH:
                    s = word_end(s);
                KIND_DOMAIN:
                begin
                    if (s.first_token)
                    begin
                        if (s.token_length != 2'd3 || s.held_byte != CH_GT)
                            s.failed = 1'b1;
                    end
                    else if (!s.token_started)
                        s.failed = 1'b1;
                    s = word_end(s);
                end
                default:
                    s.failed = 1'b1;
            endcase
        end

        name_valid = !s.failed;
        nxt        = last_byte ? STATE_RESET : s;
    end

endmodule

`default_nettype wire

// File: rtl/policy_name_syntax_checker.sv
// Path: a name's last byte is held in the input register, then its verdict in the verdict register.
// Throughput: one byte per cycle; the input stalls only when a finished verdict
//   is held by a stalled output and the next byte also ends a name.
// Reset (rst_n low, asynchronous): pipeline empty, name kind plain word,
//   checker state cleared. A configuration write also clears the name in progress.
`default_nettype none

module policy_name_syntax_checker
    import pnsc_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    // byte requests
    input  wire         byte_valid,
    output logic        byte_stall,
    input  wire  [7:0]  data_byte,
    input  wire         last_byte,
    // verdict requests
    output logic        verdict_valid,
    input  wire         verdict_stall,
    output logic        name_valid,
    // configuration write
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  name_kind
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    name_kind_t  kind_reg;
    pnsc_state_t state_reg;
    pnsc_state_t state_next;
    logic        verdict_next;
    logic        out_valid_reg;
    logic        out_verdict_reg;
    logic        out_free;
    logic        proc_go;
    logic        cfg_write;

    // Flow control
    assign out_free   = !out_valid_reg || !verdict_stall;
    assign proc_go    = in_valid_reg && (!in_last_reg || out_free);
    assign byte_stall = in_valid_reg && !proc_go;
    assign cfg_ready  = !in_valid_reg && !out_valid_reg;
    assign cfg_write  = cfg_valid && cfg_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_valid && !byte_stall)
            in_valid_reg <= 1'b1;
        else if (proc_go)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    // Byte update
    pnsc_step u_step (
        .kind       (kind_reg),
        .cur        (state_reg),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .nxt        (state_next),
        .name_valid (verdict_next)
    );

    // Checker state and name kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_WORD;
            state_reg <= STATE_RESET;
        end
        else if (cfg_write)
        begin
            kind_reg  <= name_kind_t'(name_kind);
            state_reg <= STATE_RESET;
        end
        else if (proc_go)
            state_reg <= state_next;
    end

    // Verdict register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc_go && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (!verdict_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && in_last_reg)
            out_verdict_reg <= verdict_next;
    end

    assign verdict_valid = out_valid_reg;
    assign name_valid    = out_verdict_reg;

`ifndef SYNTHESIS
    // A finished name leaves the checker in its reset state
    a_clear_after_name: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_go && in_last_reg) |=> (state_reg == STATE_RESET))
        else $error("checker state not cleared after a name");

    // A failure sticks until the name ends or the kind is rewritten
    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.failed && !(proc_go && in_last_reg) && !cfg_write) |=> state_reg.failed)
        else $error("failure flag dropped within a name");

    // The unused kind never passes a name
    a_unused_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_go && in_last_reg && kind_reg == KIND_UNUSED) |=> (verdict_valid && !name_valid))
        else $error("name passed under the unused kind");
`endif

endmodule

`default_nettype wire
